// File: rtl/sorted_list_insert_delete_defines.svh
// Assertion macros for the sorted list block.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef ASSERT_OFF
// Check an implication or condition on every clock edge outside reset.
`define SLI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
// Check that a condition is followed by another in the next cycle.
`define SLI_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: sequence check failed");
`else
`define SLI_ASSERT(lbl, clk, rst, prop)
`define SLI_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

// File: rtl/sli_pkg.sv
// Shared types and codes for the sorted list block.
`default_nettype none
package sli_pkg;

   localparam int LIST_DEPTH_DEF = 16;
   localparam int DATA_W         = 32;
   localparam int STATUS_W       = 3;
   localparam int COUNT_W        = 5;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_DUMP   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [DATA_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
      logic                last;
   } sli_rslt_type;

endpackage
`default_nettype wire

// File: rtl/sli_cmp.sv
// Shared signed compare unit used by the list sequencer.
`default_nettype none
module sli_cmp
   import sli_pkg::*;
(
   input  wire logic signed [DATA_W-1:0] a,
   input  wire logic signed [DATA_W-1:0] b,
   output logic                          lt,
   output logic                          eq
);

   assign lt = (a < b);
   assign eq = (a == b);

endmodule
`default_nettype wire

// File: rtl/sli_core.sv
// List sequencer: entry memory, scan counter and result generation.
`default_nettype none
`include "sorted_list_insert_delete_defines.svh"
module sli_core
   import sli_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_type,
   input  wire logic [DATA_W-1:0] req_value,
   output logic                   req_stall,
   input  wire logic              out_free,
   output logic                   rslt_valid,
   output sli_rslt_type           rslt
);

   localparam int IDXW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNTW = $clog2(LIST_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_PLACE, S_FINISH} state_type;

   state_type            state_ff, state_in;
   logic [1:0]           op_ff, op_in;
   logic [DATA_W-1:0]    val_ff, val_in;
   logic [IDXW-1:0]      idx_ff, idx_in;
   logic [CNTW-1:0]      held_ff, held_in;
   logic                 found_ff, found_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   logic [DATA_W-1:0]    mem [LIST_DEPTH];
   logic [DATA_W-1:0]    rdata_ff;
   logic                 wr_en;
   logic [IDXW-1:0]      wr_addr;
   logic [DATA_W-1:0]    wr_data;

   logic                 cmp_lt, cmp_eq;
   logic [CNTW-1:0]      held_m1, idx_p1;
   logic [CNTW+4:0]      count_ext;
   logic                 last_hit;

   sli_cmp u_cmp (
      .a  (val_ff),
      .b  (rdata_ff),
      .lt (cmp_lt),
      .eq (cmp_eq)
   );

   assign held_m1   = held_ff - CNTW'(1);
   assign idx_p1    = CNTW'(idx_ff) + CNTW'(1);
   assign last_hit  = (idx_p1 == held_ff);
   assign count_ext = {5'd0, held_ff};
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      held_in    = held_ff;
      found_in   = found_ff;
      status_in  = status_ff;
      wr_en      = 1'b0;
      wr_addr    = idx_ff;
      wr_data    = val_ff;
      rslt_valid = 1'b0;
      rslt.data   = '0;
      rslt.status = status_ff;
      rslt.count  = count_ext[4:0];
      rslt.last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_type;
               val_in   = req_value;
               found_in = 1'b0;
               idx_in   = '0;
               unique case (req_type)
                  REQ_INSERT: begin
                     if (held_ff == CNTW'(LIST_DEPTH)) begin
                        status_in = ST_FULL;
                        state_in  = S_FINISH;
                     end else if (held_ff == '0) begin
                        state_in = S_PLACE;
                     end else begin
                        // scan downward from the largest entry
                        idx_in   = held_m1[IDXW-1:0];
                        state_in = S_SCAN;
                     end
                  end
                  REQ_DELETE: begin
                     if (held_ff == '0) begin
                        status_in = ST_NOTFOUND;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  REQ_DUMP: begin
                     if (held_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            case (op_ff)
               REQ_INSERT: begin
                  wr_en   = 1'b1;
                  wr_addr = idx_p1[IDXW-1:0];
                  if (cmp_lt) begin
                     // shift the larger entry up one place
                     wr_data = rdata_ff;
                     if (idx_ff == '0) begin
                        state_in = S_PLACE;
                     end else begin
                        idx_in = idx_ff - IDXW'(1);
                     end
                  end else begin
                     wr_data   = val_ff;
                     held_in   = held_ff + CNTW'(1);
                     status_in = ST_DONE;
                     state_in  = S_FINISH;
                  end
               end
               REQ_DELETE: begin
                  if (found_ff) begin
                     // close the gap left by the removed entry
                     wr_en   = 1'b1;
                     wr_addr = idx_ff - IDXW'(1);
                     wr_data = rdata_ff;
                  end
                  found_in = found_ff | cmp_eq;
                  if (last_hit) begin
                     state_in = S_FINISH;
                     if (found_in) begin
                        held_in   = held_m1;
                        status_in = ST_DONE;
                     end else begin
                        status_in = ST_NOTFOUND;
                     end
                  end else begin
                     idx_in = idx_p1[IDXW-1:0];
                  end
               end
               default: begin
                  // dump: hold the entry until the output register frees up
                  if (out_free) begin
                     rslt_valid  = 1'b1;
                     rslt.data   = rdata_ff;
                     rslt.status = ST_ENTRY;
                     rslt.last   = last_hit;
                     if (last_hit) begin
                        state_in = S_IDLE;
                     end else begin
                        idx_in = idx_p1[IDXW-1:0];
                     end
                  end
               end
            endcase
         end
         S_PLACE: begin
            wr_en     = 1'b1;
            wr_addr   = idx_ff;
            wr_data   = val_ff;
            held_in   = held_ff + CNTW'(1);
            status_in = ST_DONE;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rslt_valid = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         found_ff <= found_in;
      end
      op_ff     <= op_in;
      val_ff    <= val_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
   end

   // read address follows the next index so data lines up with idx_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[idx_in];
   end

   `SLI_ASSERT(a_held_bound, clock, reset, held_ff <= CNTW'(LIST_DEPTH))
   `SLI_ASSERT(a_load_free, clock, reset, rslt_valid |-> out_free)
   `SLI_ASSERT(a_full_status, clock, reset, (rslt_valid && rslt.status == ST_FULL) |-> (held_ff == CNTW'(LIST_DEPTH)))
   `SLI_ASSERT(a_insert_room, clock, reset, (state_ff == S_SCAN && op_ff == REQ_INSERT) |-> (held_ff < CNTW'(LIST_DEPTH)))
   `SLI_ASSERT_NEXT(a_finish_idle, clock, reset, state_ff == S_FINISH && out_free, state_ff == S_IDLE)

endmodule
`default_nettype wire

// File: rtl/sorted_list_insert_delete.sv
// Sorted list block: ascending list of signed values with insert, delete and dump.
//
// Requests arrive on the req_ channel (req_valid, req_stall, req_type, req_value)
// and results leave on the rsp_ channel (rsp_valid, rsp_stall, rsp_data,
// rsp_status, rsp_count, rsp_last). A word moves when valid is high and stall
// is low. One request is worked on at a time; req_stall stays high meanwhile.
// Insert walks down from the largest entry, one entry per cycle, shifting
// larger entries up. Delete walks the whole list once. Dump gives one entry
// word per cycle while the output is not stalled, held words, the last with
// rsp_last set. A full insert, a delete on an empty list and an empty dump
// go straight to the finish state to answer. req_stall drops as the final
// word loads, and the next request can then be taken. The pace is set by
// the entry memory (one read and one write a cycle) and the shared comparator.
// Request code three is dropped without a result.
// A result sits in the output register until taken; while it is held and
// rsp_stall is high, the sequencer stops at its next result and resumes
// when the register frees up.
// Reset empties the list and clears any pending result.
`default_nettype none
module sorted_list_insert_delete
   import sli_pkg::*;
#(
   parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [1:0]          req_type,
   input  wire logic [DATA_W-1:0]   req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [DATA_W-1:0]        rsp_data,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic                     rsp_last
);

   logic         rsp_valid_ff;
   sli_rslt_type rsp_ff;
   sli_rslt_type rslt;
   logic         rslt_valid;
   logic         out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   sli_core #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_type   (req_type),
      .req_value  (req_value),
      .req_stall  (req_stall),
      .out_free   (out_free),
      .rslt_valid (rslt_valid),
      .rslt       (rslt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rslt_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rslt_valid) begin
         rsp_ff <= rslt;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff.data;
   assign rsp_status = rsp_ff.status;
   assign rsp_count  = rsp_ff.count;
   assign rsp_last   = rsp_ff.last;

endmodule
`default_nettype wire
